/* hdl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is active
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* hdl/mmfir_pkg.sv */
// types, constants and codes of the multichannel mixing fir
package mmfir_pkg;

	localparam int CHANNELS      = 4;
	localparam int MAX_TAPS      = 64;
	localparam int SAMPLE_FIELDS = 4;

	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int TAP_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int NCH_W  = $clog2(CHANNELS + 1);
	localparam int NTAP_W = $clog2(MAX_TAPS + 1);

	localparam int SAMP_W     = 16;
	localparam int PROD_W     = 2 * SAMP_W;
	localparam int ACC_RAW_W  = PROD_W + $clog2(CHANNELS * MAX_TAPS + 1);
	localparam int ACC_W      = (ACC_RAW_W > 40) ? ACC_RAW_W : 40;
	localparam int FRAC_SHIFT = 15;
	localparam int OUT_W      = 24;

	localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	// configuration registers
	localparam int ACH_W      = 3;
	localparam int ATAP_W     = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CHANNELS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_TAPS     = 1'd1;
	localparam logic [ACH_W-1:0]     ACT_CH_RESET        = 3'd4;
	localparam logic [ATAP_W-1:0]    ACT_TAPS_RESET      = 7'd64;

	// operation codes
	localparam logic [1:0] OP_COEF  = 2'd0;
	localparam logic [1:0] OP_FRAME = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0]               op;
		logic signed [SAMP_W-1:0] sample_ch0;
		logic signed [SAMP_W-1:0] sample_ch1;
		logic signed [SAMP_W-1:0] sample_ch2;
		logic signed [SAMP_W-1:0] sample_ch3;
		logic [1:0]               coef_channel;
		logic [5:0]               coef_tap;
		logic signed [SAMP_W-1:0] coef_value;
	} in_item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] out_sample;
		logic                    saturated;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic             frame;
		logic             wr_coef;
		logic             clr_hist;
		logic             issue;
		logic [TAP_W-1:0] tap;
		logic             load_out;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pipe_busy;
		logic out_free;
	} dp_status_t;

endpackage

/* hdl/mmfir_ctrl.sv */
// controller state machine: accepts items and steps the taps of a frame
module mmfir_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [1:0]                    op,
	input  logic [mmfir_pkg::NTAP_W-1:0]  ntap,
	input  mmfir_pkg::dp_status_t         sts,
	output logic                          in_stall,
	output mmfir_pkg::ctrl_cmd_t          cmd
);
	import mmfir_pkg::*;

	state_t           state_q, state_d;
	logic [TAP_W-1:0] tap_q;
	logic             accept;
	logic             last_tap;

	assign accept   = in_valid && !in_stall;
	assign last_tap = (NTAP_W'(tap_q) + NTAP_W'(1)) == ntap;

	// state register and tap counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tap_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept && op == OP_FRAME)
				tap_q <= '0;
			else if (state_q == ST_MAC)
				tap_q <= tap_q + 1'b1;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && op == OP_FRAME)
					state_d = (ntap == '0) ? ST_DRAIN : ST_MAC;
			end
			ST_MAC: begin
				if (last_tap)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy && sts.out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall     = (state_q != ST_IDLE);
		cmd.frame    = accept && op == OP_FRAME;
		cmd.wr_coef  = accept && op == OP_COEF;
		cmd.clr_hist = accept && op == OP_CLEAR;
		cmd.issue    = (state_q == ST_MAC);
		cmd.tap      = tap_q;
		cmd.load_out = (state_q == ST_DRAIN) && !sts.pipe_busy && sts.out_free;
	end

endmodule

/* hdl/mmfir_datapath.sv */
// datapath: history and kernel banks, one mac lane per channel, output register
module mmfir_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mmfir_pkg::in_item_t          in_data,
	input  logic [mmfir_pkg::NCH_W-1:0]  nch,
	input  mmfir_pkg::ctrl_cmd_t         cmd,
	input  logic                         out_stall,
	output logic                         out_valid,
	output mmfir_pkg::out_item_t         out_data,
	output mmfir_pkg::dp_status_t        sts
);
	import mmfir_pkg::*;

	localparam int Y_W = ACC_W - FRAC_SHIFT;

	// per-lane banks
	logic signed [SAMP_W-1:0] hist_mem [CHANNELS][MAX_TAPS];
	logic signed [SAMP_W-1:0] coef_mem [CHANNELS][MAX_TAPS];
	logic                     coef_vld_q [CHANNELS][MAX_TAPS];

	logic [TAP_W-1:0]  wp_q, wp_next, rd_ptr_q, rd_ptr_prev;
	logic [NTAP_W-1:0] fill_q;

	logic signed [SAMP_W-1:0] fld [SAMPLE_FIELDS];
	logic signed [SAMP_W-1:0] lane_sample [CHANNELS];
	logic [CHANNELS-1:0]      lane_en;
	logic [CHANNELS-1:0]      coef_we;
	logic [TAP_W-1:0]         coef_addr;
	logic                     coef_ok;

	logic signed [SAMP_W-1:0] hist_rd_s1 [CHANNELS];
	logic signed [SAMP_W-1:0] coef_rd_s1 [CHANNELS];
	logic [CHANNELS-1:0]      cv_s1;
	logic                     hv_s1, vld_s1;
	logic signed [PROD_W-1:0] prod_s2 [CHANNELS];
	logic                     vld_s2;
	logic signed [ACC_W-1:0]  sum_s3;
	logic                     vld_s3;
	logic signed [ACC_W-1:0]  lane_sum;
	logic signed [ACC_W-1:0]  acc_q;

	logic [Y_W-1:0]           y;
	logic [Y_W-OUT_W:0]       y_top;
	logic                     fits;
	out_item_t                result;
	out_item_t                out_q;
	logic                     out_valid_q;

	// frame samples per lane, lanes past the sample fields get zero
	assign fld[0] = in_data.sample_ch0;
	assign fld[1] = in_data.sample_ch1;
	assign fld[2] = in_data.sample_ch2;
	assign fld[3] = in_data.sample_ch3;

	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			lane_sample[c] = (c < SAMPLE_FIELDS) ? fld[c % SAMPLE_FIELDS] : '0;
			lane_en[c]     = NCH_W'(c) < nch;
		end
	end

	// coefficient write decode, out-of-range addresses are dropped
	assign coef_ok   = (32'(in_data.coef_channel) < CHANNELS) &&
	                   (32'(in_data.coef_tap) < MAX_TAPS);
	assign coef_addr = TAP_W'(in_data.coef_tap);

	always_comb begin
		for (int c = 0; c < CHANNELS; c++)
			coef_we[c] = cmd.wr_coef && coef_ok && (CH_W'(in_data.coef_channel) == CH_W'(c));
	end

	// circular history pointers
	assign wp_next     = (wp_q == TAP_W'(MAX_TAPS - 1)) ? '0 : wp_q + 1'b1;
	assign rd_ptr_prev = (rd_ptr_q == '0) ? TAP_W'(MAX_TAPS - 1) : rd_ptr_q - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (cmd.frame) begin
				wp_q     <= wp_next;
				rd_ptr_q <= wp_next;
				if (fill_q != NTAP_W'(MAX_TAPS))
					fill_q <= fill_q + 1'b1;
			end else begin
				if (cmd.issue)
					rd_ptr_q <= rd_ptr_prev;
				if (cmd.clr_hist)
					fill_q <= '0;
			end
		end
	end

	// bank writes and registered reads
	always_ff @(posedge clk) begin
		for (int c = 0; c < CHANNELS; c++) begin
			if (cmd.frame)
				hist_mem[c][wp_next] <= lane_sample[c];
			if (coef_we[c])
				coef_mem[c][coef_addr] <= in_data.coef_value;
			hist_rd_s1[c] <= hist_mem[c][rd_ptr_q];
			coef_rd_s1[c] <= coef_mem[c][cmd.tap];
		end
	end

	// kernel valid bits, unwritten taps read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++)
				for (int k = 0; k < MAX_TAPS; k++)
					coef_vld_q[c][k] <= 1'b0;
		end else begin
			for (int c = 0; c < CHANNELS; c++)
				if (coef_we[c])
					coef_vld_q[c][coef_addr] <= 1'b1;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// stage 1 qualifiers: history age within fill count, kernel tap written
	always_ff @(posedge clk) begin
		hv_s1 <= NTAP_W'(cmd.tap) < fill_q;
		for (int c = 0; c < CHANNELS; c++)
			cv_s1[c] <= coef_vld_q[c][cmd.tap] && lane_en[c];
	end

	// stage 2 signed multiply per lane
	always_ff @(posedge clk) begin
		for (int c = 0; c < CHANNELS; c++)
			prod_s2[c] <= (hv_s1 && cv_s1[c]) ? hist_rd_s1[c] * coef_rd_s1[c] : PROD_W'(0);
	end

	// stage 3 lane sum
	always_comb begin
		lane_sum = '0;
		for (int c = 0; c < CHANNELS; c++)
			lane_sum = lane_sum + ACC_W'(prod_s2[c]);
	end

	always_ff @(posedge clk) begin
		sum_s3 <= lane_sum;
	end

	// accumulator, cleared when a frame is taken
	always_ff @(posedge clk) begin
		if (cmd.frame)
			acc_q <= '0;
		else if (vld_s3)
			acc_q <= acc_q + sum_s3;
	end

	// floor shift and saturation
	always_comb begin
		y     = acc_q[ACC_W-1:FRAC_SHIFT];
		y_top = y[Y_W-1:OUT_W-1];
		fits  = (&y_top) || !(|y_top);
		result.out_sample = fits ? y[OUT_W-1:0] : (y[Y_W-1] ? OUT_MIN : OUT_MAX);
		result.saturated  = !fits;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out)
			out_q <= result;
	end

	assign out_valid     = out_valid_q;
	assign out_data      = out_q;
	assign sts.pipe_busy = vld_s1 || vld_s2 || vld_s3;
	assign sts.out_free  = !out_valid_q || !out_stall;

endmodule

/* hdl/multichannel_mixing_fir_core.sv */
// top level of the multichannel mixing fir: configuration registers and wiring
//
// channel   direction  handshake            payload
// in        input      in_valid / in_stall  in_item_t
// out       output     out_valid / out_stall out_item_t
// cfg       input      cfg_we               cfg_index, cfg_data
//
// a frame steps the taps up to active_taps (clamped to MAX_TAPS), none when that is zero:
// one mac per lane and tap a cycle, three stages drain, then the output register loads the result
// coefficient writes, clears and unused codes leave the block idle and give no result
// reset empties the history by a fill count and the kernels by valid bits; no clearing pass
// a finished result waits in the output register while the next item is taken
// while a stalled result is still held, a further frame waits before its result
module multichannel_mixing_fir_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  mmfir_pkg::in_item_t                 in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output mmfir_pkg::out_item_t                out_data,
	input  logic                                cfg_we,
	input  logic [mmfir_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mmfir_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import mmfir_pkg::*;

	logic [ACH_W-1:0]  act_ch_q;
	logic [ATAP_W-1:0] act_taps_q;
	logic [NCH_W-1:0]  nch;
	logic [NTAP_W-1:0] ntap;
	ctrl_cmd_t         cmd;
	dp_status_t        sts;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_ch_q   <= ACT_CH_RESET;
			act_taps_q <= ACT_TAPS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ACTIVE_CHANNELS: act_ch_q   <= cfg_data[ACH_W-1:0];
				REG_ACTIVE_TAPS:     act_taps_q <= cfg_data[ATAP_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp to what the store holds
	assign nch  = (32'(act_ch_q) > CHANNELS) ? NCH_W'(CHANNELS) : NCH_W'(act_ch_q);
	assign ntap = (32'(act_taps_q) > MAX_TAPS) ? NTAP_W'(MAX_TAPS) : NTAP_W'(act_taps_q);

	mmfir_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (in_data.op),
		.ntap     (ntap),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	mmfir_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.nch       (nch),
		.cmd       (cmd),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.sts       (sts)
	);

endmodule

/* hdl/mmfir_checker.sv */
// port-level checker for the multichannel mixing fir, bound to the top level
`include "assert_macros.svh"

module mmfir_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  mmfir_pkg::in_item_t  in_data,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  mmfir_pkg::out_item_t out_data
);
	import mmfir_pkg::*;

	logic in_xfer;
	assign in_xfer = in_valid && !in_stall;

	// a stalled result holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data))

	// a clipped result sits at one of the range limits
	`ASSERT_SAME(a_sat_limit, clk, arst_n, out_valid && out_data.saturated, (out_data.out_sample == OUT_MAX) || (out_data.out_sample == OUT_MIN))

	// a frame transfer occupies the block the next cycle
	`ASSERT_NEXT(a_frame_busy, clk, arst_n, in_xfer && in_data.op == OP_FRAME, in_stall)

	// other transfers finish in their own cycle
	`ASSERT_NEXT(a_other_free, clk, arst_n, in_xfer && in_data.op != OP_FRAME, !in_stall)

	// a new result appears as the block returns to idle
	`ASSERT_SAME(a_result_idle, clk, arst_n, $rose(out_valid), !in_stall)

endmodule

bind multichannel_mixing_fir_core mmfir_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

/* tb/sv/multichannel_mixing_fir_core_tb.sv */
// testbench of the multichannel mixing fir core: random and directed transfers against a predictor
`timescale 1ns / 1ps

module multichannel_mixing_fir_core_tb;
	import mmfir_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int TAIL_CYCLES = MAX_TAPS + 5 + 20;
	localparam int IDLE_PCT = 77;
	localparam int BOTH_PCT = 30;
	localparam longint SAT_HI = (longint'(1) << (OUT_W - 1)) - 1;
	localparam longint SAT_LO = -(longint'(1) << (OUT_W - 1));
	localparam logic signed [SAMP_W-1:0] S_MIN = 16'sh8000;
	localparam logic signed [SAMP_W-1:0] S_MAX = 16'sh7fff;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// predictor state: history position 0 is the newest sample
	logic signed [SAMP_W-1:0] mix_history [CHANNELS][MAX_TAPS];
	logic signed [SAMP_W-1:0] mix_kernel [CHANNELS][MAX_TAPS];
	logic [ACH_W-1:0] mix_channels;
	logic [ATAP_W-1:0] mix_taps;

	in_item_t pending_items[$];
	out_item_t mix_expect_q[$];
	int items_sent = 0;
	int items_taken = 0;
	int mismatch_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	multichannel_mixing_fir_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// apply one accepted item to the predictor, queue the output sample of a frame
	task automatic mix_take(input in_item_t it);
		logic signed [SAMP_W-1:0] fresh [4];
		longint acc;
		longint y;
		int nch;
		int ntap;
		out_item_t res;
		case (it.op)
			OP_COEF: begin
				if (it.coef_channel < CHANNELS && it.coef_tap < MAX_TAPS)
					mix_kernel[it.coef_channel][it.coef_tap] = it.coef_value;
			end
			OP_CLEAR: begin
				for (int c = 0; c < CHANNELS; c++)
					for (int k = 0; k < MAX_TAPS; k++)
						mix_history[c][k] = '0;
			end
			OP_FRAME: begin
				fresh[0] = it.sample_ch0;
				fresh[1] = it.sample_ch1;
				fresh[2] = it.sample_ch2;
				fresh[3] = it.sample_ch3;
				for (int c = 0; c < CHANNELS; c++) begin
					for (int k = MAX_TAPS - 1; k > 0; k--)
						mix_history[c][k] = mix_history[c][k-1];
					mix_history[c][0] = (c < SAMPLE_FIELDS) ? fresh[c] : '0;
				end
				nch = (mix_channels > CHANNELS) ? CHANNELS : int'(mix_channels);
				ntap = (mix_taps > MAX_TAPS) ? MAX_TAPS : int'(mix_taps);
				acc = 0;
				for (int c = 0; c < nch; c++)
					for (int k = 0; k < ntap; k++)
						acc += longint'(mix_history[c][k]) * longint'(mix_kernel[c][k]);
				// arithmetic shift is a floor division
				y = acc >>> FRAC_SHIFT;
				res.saturated = 1'b0;
				if (y > SAT_HI) begin
					y = SAT_HI;
					res.saturated = 1'b1;
				end else if (y < SAT_LO) begin
					y = SAT_LO;
					res.saturated = 1'b1;
				end
				res.out_sample = y[OUT_W-1:0];
				mix_expect_q = {mix_expect_q, res};
			end
			default: ;
		endcase
	endtask

	// driver: take transfers, then offer the next pending item or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				mix_take(in_data);
				items_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= pending_items.pop_front();
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// monitor: check each output transfer against the oldest expected sample
	always @(posedge clk or negedge arst_n) begin : out_check
		out_item_t want;
		if (!arst_n)
			out_stall <= 1'b0;
		else begin
			if (out_valid && !out_stall) begin
				if (mix_expect_q.size() == 0) begin
					$display("%0t: unexpected output, got sample %0d saturated %0b",
						$time, out_data.out_sample, out_data.saturated);
					mismatch_count++;
				end else begin
					want = mix_expect_q.pop_front();
					if (out_data.out_sample !== want.out_sample) begin
						$display("%0t: out_sample expected %0d got %0d",
							$time, want.out_sample, out_data.out_sample);
						mismatch_count++;
					end
					if (out_data.saturated !== want.saturated) begin
						$display("%0t: saturated expected %0b got %0b",
							$time, want.saturated, out_data.saturated);
						mismatch_count++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// item of the given code with random content in every other field
	function automatic in_item_t rand_item(input logic [1:0] op);
		logic [95:0] bits;
		in_item_t it;
		bits = {$urandom, $urandom, $urandom};
		it = bits[$bits(in_item_t)-1:0];
		it.op = op;
		return it;
	endfunction

	function automatic logic signed [SAMP_W-1:0] rand_sample();
		case ($urandom_range(7))
			0: return S_MIN;
			1: return S_MAX;
			2: return '0;
			default: return SAMP_W'($urandom);
		endcase
	endfunction

	function automatic in_item_t frame_item(input logic signed [SAMP_W-1:0] s0, s1, s2, s3);
		in_item_t it;
		it = rand_item(OP_FRAME);
		it.sample_ch0 = s0;
		it.sample_ch1 = s1;
		it.sample_ch2 = s2;
		it.sample_ch3 = s3;
		return it;
	endfunction

	function automatic in_item_t coef_item(input logic [1:0] ch, input logic [5:0] tap,
		input logic signed [SAMP_W-1:0] value);
		in_item_t it;
		it = rand_item(OP_COEF);
		it.coef_channel = ch;
		it.coef_tap = tap;
		it.coef_value = value;
		return it;
	endfunction

	task automatic send(input in_item_t it);
		pending_items = {pending_items, it};
		items_sent++;
	endtask

	// wait until every item is taken and every sample has come, then let the core settle
	task automatic wait_idle();
		while (items_taken != items_sent || mix_expect_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ACTIVE_CHANNELS: mix_channels = value[ACH_W-1:0];
			REG_ACTIVE_TAPS: mix_taps = value[ATAP_W-1:0];
			default: ;
		endcase
	endtask

	// upper data bits of the channel register are don't-care, so they get random values
	task automatic set_mix(input logic [ACH_W-1:0] nch, input logic [ATAP_W-1:0] ntap);
		write_reg(REG_ACTIVE_CHANNELS, {(CFG_DATA_W - ACH_W)'($urandom), nch});
		write_reg(REG_ACTIVE_TAPS, ntap);
	endtask

	task automatic set_idling(input int send_pct, input int stall_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
	endtask

	// stimulus
	initial begin : stim
		int r;
		logic [ACH_W-1:0] nch;
		logic [ATAP_W-1:0] ntap;
		for (int c = 0; c < CHANNELS; c++)
			for (int k = 0; k < MAX_TAPS; k++) begin
				mix_history[c][k] = '0;
				mix_kernel[c][k] = '0;
			end
		mix_channels = ACT_CH_RESET;
		mix_taps = ACT_TAPS_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset registers, kernel extremes, clear and the unused code
		send(frame_item(S_MIN, S_MIN, S_MIN, S_MIN));
		send(coef_item(2'd0, 6'd0, S_MAX));
		send(coef_item(2'd1, 6'd63, S_MIN));
		send(coef_item(2'd3, 6'd1, S_MIN));
		send(coef_item(2'd2, 6'd0, -16'sd1));
		send(frame_item(S_MAX, S_MIN, S_MAX, S_MIN));
		send(frame_item(S_MIN, S_MAX, S_MIN, S_MAX));
		send(frame_item('0, '0, '0, '0));
		send(rand_item(OP_UNUSED));
		send(frame_item(rand_sample(), rand_sample(), rand_sample(), rand_sample()));
		send(rand_item(OP_CLEAR));
		send(frame_item(-16'sd1, -16'sd1, -16'sd1, -16'sd1));
		wait_idle();

		// zero channels and zero taps still give a sample
		set_mix(3'd0, 7'd0);
		send(frame_item(S_MIN, S_MIN, S_MIN, S_MIN));
		wait_idle();

		// register values above the core sizes
		set_mix(3'd7, 7'd127);
		send(frame_item(S_MAX, S_MAX, S_MAX, S_MAX));
		send(frame_item(S_MIN, S_MAX, S_MIN, S_MAX));
		wait_idle();

		set_mix(3'd1, 7'd1);
		send(frame_item(S_MAX, S_MIN, S_MAX, S_MIN));
		send(coef_item(2'd0, 6'd0, S_MIN));
		send(frame_item(S_MIN, S_MAX, S_MAX, S_MAX));
		wait_idle();

		set_mix(3'd5, 7'd65);
		send(frame_item(S_MAX, S_MAX, S_MIN, S_MIN));
		wait_idle();

		// random phases, each with an idling setting chosen by phase and its own register setting
		for (int p = 0; p < 6; p++) begin
			case (p % 4)
				0: set_idling(0, 0);
				1: set_idling(IDLE_PCT, 0);
				2: set_idling(0, IDLE_PCT);
				default: set_idling(BOTH_PCT, BOTH_PCT);
			endcase
			if (p == 3) begin
				// full-scale kernels and history drive the sum into saturation
				set_mix($urandom_range(1) ? 3'd4 : 3'd7, $urandom_range(1) ? 7'd64 : 7'd127);
				send(rand_item(OP_CLEAR));
				for (int c = 0; c < CHANNELS; c++)
					for (int k = 0; k < MAX_TAPS; k++)
						send(coef_item(c[1:0], k[5:0], S_MIN));
				for (int i = 0; i < MAX_TAPS + 6; i++)
					send(frame_item(S_MIN, S_MIN, S_MIN, S_MIN));
				for (int i = 0; i < 20; i++)
					send(frame_item(
						$urandom_range(9) ? S_MIN : rand_sample(),
						$urandom_range(9) ? S_MIN : rand_sample(),
						$urandom_range(9) ? S_MIN : rand_sample(),
						$urandom_range(9) ? S_MIN : rand_sample()));
			end else begin
				nch = ($urandom_range(99) < 80) ? ACH_W'($urandom_range(1, CHANNELS))
					: ACH_W'($urandom_range(7));
				case ($urandom_range(5))
					0: ntap = 7'd64;
					1: ntap = 7'd1;
					2: ntap = ATAP_W'($urandom_range(65, 127));
					3: ntap = ATAP_W'($urandom_range(1, 64));
					default: ntap = ATAP_W'($urandom_range(2, 63));
				endcase
				set_mix(nch, ntap);
				for (int i = 0; i < 70; i++) begin
					r = $urandom_range(99);
					if (r < 70)
						send(frame_item(rand_sample(), rand_sample(), rand_sample(),
							rand_sample()));
					else if (r < 88)
						send(coef_item(2'($urandom), 6'($urandom), rand_sample()));
					else if (r < 94)
						send(rand_item(OP_CLEAR));
					else
						send(rand_item(OP_UNUSED));
				end
			end
			wait_idle();
		end

		if (mismatch_count == 0)
			$display("[multichannel_mixing_fir_core] OK");
		else
			$display("[multichannel_mixing_fir_core] ERROR");
		$finish;
	end

	// run limit
	initial begin
		#3_000_000;
		$display("[multichannel_mixing_fir_core] ERROR");
		$finish;
	end

endmodule
